FILE: hdl/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants for the LED matrix driver serial writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

  // Field widths
  localparam int unsigned FuncW    = 3;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned IdW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CntW     = 5;   // holds 0..16 slots

  // Frame lengths in bit slots
  localparam logic [CntW-1:0] CmdBits   = 5'd12;
  localparam logic [CntW-1:0] NibBits   = 5'd14;
  localparam logic [CntW-1:0] BeginBits = 5'd10;
  localparam logic [CntW-1:0] WordBits  = 5'd16;

  localparam logic [3:0] LevelMax = 4'hF;

  // Request codes
  typedef enum logic [FuncW-1:0] {
    FUNC_CMD    = 3'd0,
    FUNC_BRIGHT = 3'd1,
    FUNC_NIBBLE = 3'd2,
    FUNC_BEGIN  = 3'd3,
    FUNC_WORD   = 3'd4,
    FUNC_END    = 3'd5
  } func_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMMAND_ID      = 2'd0,
    CFG_WRITE_ID        = 2'd1,
    CFG_BRIGHTNESS_BASE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]   command_id;
    logic [IdW-1:0]   write_id;
    logic [ByteW-1:0] brightness_base;
  } cfg_t;

  // One decoded request: optional release slot, then nbits of word MSB first
  typedef struct packed {
    logic              pre_release;
    logic [ValueW-1:0] word;        // left aligned
    logic [CntW-1:0]   nbits;
    logic              rel_after;
    logic              frame_open;  // frame state after this request
  } job_t;

endpackage

`default_nettype wire

FILE: hdl/lds_decode.sv
// ----------------------------------------------------------------------------
// lds_decode
// Turns one request into a left-aligned bit word, a slot count and the
// chip-select release flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lds_decode (
  input  wire logic [lds_pkg::FuncW-1:0]  func_i,
  input  wire logic [lds_pkg::ValueW-1:0] value_i,
  input  wire logic [lds_pkg::AddrW-1:0]  address_i,
  input  wire lds_pkg::cfg_t              cfg_i,
  input  wire logic                       frame_open_i,
  output lds_pkg::job_t                   job_o
);
  import lds_pkg::*;

  logic [3:0]       level;
  logic [ByteW-1:0] bright_cmd;

  // Brightness clamped to 15 and merged into the base byte
  assign level      = (value_i[ValueW-1:4] != '0) ? LevelMax : value_i[3:0];
  assign bright_cmd = cfg_i.brightness_base | {4'd0, level};

  always_comb begin
    job_o             = '0;
    job_o.frame_open  = frame_open_i;
    case (func_e'(func_i))
      FUNC_CMD: begin
        job_o.pre_release = frame_open_i;
        job_o.word        = {cfg_i.command_id, value_i[ByteW-1:0], 1'b0, 4'd0};
        job_o.nbits       = CmdBits;
        job_o.rel_after   = 1'b1;
        job_o.frame_open  = 1'b0;
      end
      FUNC_BRIGHT: begin
        job_o.pre_release = frame_open_i;
        job_o.word        = {cfg_i.command_id, bright_cmd, 1'b0, 4'd0};
        job_o.nbits       = CmdBits;
        job_o.rel_after   = 1'b1;
        job_o.frame_open  = 1'b0;
      end
      FUNC_NIBBLE: begin
        job_o.pre_release = frame_open_i;
        job_o.word        = {cfg_i.write_id, address_i, value_i[3:0], 2'd0};
        job_o.nbits       = NibBits;
        job_o.rel_after   = 1'b1;
        job_o.frame_open  = 1'b0;
      end
      FUNC_BEGIN: begin
        job_o.pre_release = frame_open_i;
        job_o.word        = {cfg_i.write_id, address_i, 6'd0};
        job_o.nbits       = BeginBits;
        job_o.frame_open  = 1'b1;
      end
      FUNC_WORD: begin
        job_o.word  = value_i;
        job_o.nbits = WordBits;
      end
      FUNC_END: begin
        job_o.pre_release = frame_open_i;
        job_o.frame_open  = 1'b0;
      end
      default: begin
        // undefined codes: no slots, state kept
        job_o.frame_open = frame_open_i;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/led_driver_serial_writer_core.sv
// ----------------------------------------------------------------------------
// led_driver_serial_writer_core
// Serializes LED matrix driver requests into write-strobe bit slots.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | func, value, address
//  out     | output    | out_valid_o / out_stall_i| data_bit, strobe_res,
//          |           |                         | release_select, last
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One slot leaves per cycle while the output does not stall; a request holds
//  the input until its slots are out (none, else a release slot plus up to 14
//  bits, or 16 for a frame word), as set by the shift register and slot counter.
//  The next request loads while the last slot of the current one goes out.
//  Reset is asynchronous, active low; the frame is closed and the registers
//  return to command_id 4, write_id 5, brightness_base 160.
//  A stall on the output holds the slot register and the shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_driver_serial_writer_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request beats
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [lds_pkg::FuncW-1:0]    in_func_i,
  input  wire logic [lds_pkg::ValueW-1:0]   in_value_i,
  input  wire logic [lds_pkg::AddrW-1:0]    in_address_i,
  // slot beats
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              out_data_bit_o,
  output logic                              out_strobe_res_o,
  output logic                              out_release_select_o,
  output logic                              out_last_o,
  // register writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lds_pkg::ByteW-1:0]    cfg_data_i
);
  import lds_pkg::*;

  cfg_t              cfg_q;
  logic              frame_open_q;
  job_t              job;

  logic              pre_q;
  logic [ValueW-1:0] word_q;
  logic [CntW-1:0]   cnt_q;
  logic              rel_after_q;

  logic              out_valid_q;
  logic              data_q, strobe_q, rel_q, last_q;

  logic              job_active, emit, slot_last, in_accept;
  logic              slot_data, slot_strobe, slot_rel;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_id      <= 3'd4;
      cfg_q.write_id        <= 3'd5;
      cfg_q.brightness_base <= 8'd160;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COMMAND_ID:      cfg_q.command_id      <= cfg_data_i[IdW-1:0];
        CFG_WRITE_ID:        cfg_q.write_id        <= cfg_data_i[IdW-1:0];
        CFG_BRIGHTNESS_BASE: cfg_q.brightness_base <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lds_decode u_decode (
    .func_i       (in_func_i),
    .value_i      (in_value_i),
    .address_i    (in_address_i),
    .cfg_i        (cfg_q),
    .frame_open_i (frame_open_q),
    .job_o        (job)
  );

  // Slot selection from the shifter
  assign job_active  = pre_q || (cnt_q != '0);
  assign emit        = job_active && (!out_valid_q || !out_stall_i);
  assign slot_data   = pre_q ? 1'b0 : word_q[ValueW-1];
  assign slot_strobe = !pre_q;
  assign slot_rel    = pre_q ? 1'b1 : (rel_after_q && (cnt_q == CntW'(1)));
  assign slot_last   = pre_q ? (cnt_q == '0) : (cnt_q == CntW'(1));

  assign in_stall_o  = job_active && !(emit && slot_last);
  assign in_accept   = in_valid_i && !in_stall_o;

  // Frame state tracks accepted requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else if (in_accept) begin
      frame_open_q <= job.frame_open;
    end
  end

  // Shift register and slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= 1'b0;
      cnt_q <= '0;
    end else if (in_accept) begin
      pre_q <= job.pre_release;
      cnt_q <= job.nbits;
    end else if (emit) begin
      if (pre_q) begin
        pre_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q      <= job.word;
      rel_after_q <= job.rel_after;
    end else if (emit && !pre_q) begin
      word_q <= {word_q[ValueW-2:0], 1'b0};
    end
  end

  // Output slot register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q   <= slot_data;
      strobe_q <= slot_strobe;
      rel_q    <= slot_rel;
      last_q   <= slot_last;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_bit_o       = data_q;
  assign out_strobe_res_o     = strobe_q;
  assign out_release_select_o = rel_q;
  assign out_last_o           = last_q;

endmodule

`default_nettype wire

FILE: hdl/lds_checker.sv
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks on the serial writer slots, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lds_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic out_data_bit_o,
  input wire logic out_strobe_res_o,
  input wire logic out_release_select_o,
  input wire logic out_last_o
);

  // A stalled slot beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_bit_o) &&
      $stable(out_strobe_res_o) && $stable(out_release_select_o) && $stable(out_last_o))
    else $error("stalled slot changed");

  // A slot without a strobe is always a select release
  a_nostrobe_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_strobe_res_o |-> out_release_select_o)
    else $error("non-strobe slot without release");

  // A slot without a strobe drives the data line low
  a_rel_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_strobe_res_o |-> !out_data_bit_o)
    else $error("release slot with data high");

endmodule

bind led_driver_serial_writer_core lds_checker u_lds_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .out_data_bit_o       (out_data_bit_o),
  .out_strobe_res_o     (out_strobe_res_o),
  .out_release_select_o (out_release_select_o),
  .out_last_o           (out_last_o)
);

`default_nettype wire

FILE: tb/tb_led_driver_serial_writer_core.sv
// ----------------------------------------------------------------------------
// tb_led_driver_serial_writer_core
// Self-checking bench for the LED matrix driver serial writer. Requests go in
// through the stall handshake; every bit slot that comes out is compared,
// field by field, with slots predicted from a behavioral serializer. Phases:
// directed requests under reset settings, register sweeps, and random traffic
// built mostly from screen frames, first with random idle bursts on both channels, then without.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_driver_serial_writer_core;
  import lds_pkg::*;

  // Undefined request codes, ignored by the block
  localparam logic [FuncW-1:0]   FuncRsvd6  = 3'd6;
  localparam logic [FuncW-1:0]   FuncRsvd7  = 3'd7;
  // Unused register index
  localparam logic [CfgIdxW-1:0] CfgRsvdIdx = 2'd3;

  localparam int QuietCycles = 40;
  localparam int CycleLimit  = 600000;

  // One expected bit slot
  typedef struct packed {
    logic data_bit;
    logic strobe_res;
    logic release_select;
    logic last;
  } bit_slot_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [FuncW-1:0]  in_func_i;
  logic [ValueW-1:0] in_value_i;
  logic [AddrW-1:0]  in_address_i;
  logic out_valid_o;
  logic out_stall_i;
  logic out_data_bit_o;
  logic out_strobe_res_o;
  logic out_release_select_o;
  logic out_last_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;

  // Shadow of the block's registers and frame state
  logic [IdW-1:0]   cmd_id_q;
  logic [IdW-1:0]   wr_id_q;
  logic [ByteW-1:0] bright_base_q;
  logic             frame_open_q;

  bit_slot_t pending_slots[$];
  int  err_count;
  int  sent_requests;
  int  cycle_count;
  int  stall_left;
  bit  idle_on;

  led_driver_serial_writer_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_func_i           (in_func_i),
    .in_value_i          (in_value_i),
    .in_address_i        (in_address_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_data_bit_o      (out_data_bit_o),
    .out_strobe_res_o    (out_strobe_res_o),
    .out_release_select_o(out_release_select_o),
    .out_last_o          (out_last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_led_driver_serial_writer_core: FAIL");
      $finish;
    end
  end

  // Output stall bursts
  always @(posedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Slot checker: each accepted beat against the oldest expected slot
  always @(posedge clk_i) begin
    bit_slot_t exp_slot;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_slots.size() == 0) begin
        $error("unexpected slot: data_bit %0b strobe_res %0b release_select %0b last %0b",
               out_data_bit_o, out_strobe_res_o, out_release_select_o, out_last_o);
        err_count++;
      end else begin
        exp_slot = pending_slots.pop_front();
        if (out_data_bit_o !== exp_slot.data_bit) begin
          $error("data_bit: expected %0b, got %0b", exp_slot.data_bit, out_data_bit_o);
          err_count++;
        end
        if (out_strobe_res_o !== exp_slot.strobe_res) begin
          $error("strobe_res: expected %0b, got %0b", exp_slot.strobe_res, out_strobe_res_o);
          err_count++;
        end
        if (out_release_select_o !== exp_slot.release_select) begin
          $error("release_select: expected %0b, got %0b",
                 exp_slot.release_select, out_release_select_o);
          err_count++;
        end
        if (out_last_o !== exp_slot.last) begin
          $error("last: expected %0b, got %0b", exp_slot.last, out_last_o);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Slot predictor
  // ---------------------------------------------------------------------------

  // MSB-first bits; release on the final bit when asked
  task automatic queue_bits(input logic [ValueW-1:0] word, input int nbits,
                            input logic rel_after);
    bit_slot_t s;
    for (int i = nbits; i > 0; i--) begin
      s.data_bit       = word[i-1];
      s.strobe_res     = 1'b1;
      s.release_select = rel_after && (i == 1);
      s.last           = 1'b0;
      pending_slots.push_back(s);
    end
  endtask

  // Release slot when a frame holds chip select
  task automatic queue_close;
    bit_slot_t s;
    if (frame_open_q) begin
      s = '{data_bit: 1'b0, strobe_res: 1'b0, release_select: 1'b1, last: 1'b0};
      pending_slots.push_back(s);
      frame_open_q = 1'b0;
    end
  endtask

  task automatic queue_command(input logic [ByteW-1:0] cmd);
    queue_close();
    queue_bits({4'b0, cmd_id_q, cmd, 1'b0}, 12, 1'b1);
  endtask

  task automatic serialize_request(input logic [FuncW-1:0] func,
                                   input logic [ValueW-1:0] value,
                                   input logic [AddrW-1:0] addr);
    int        n_before;
    logic [3:0] level;
    bit_slot_t tail;
    n_before = pending_slots.size();
    case (func)
      FUNC_CMD: queue_command(value[ByteW-1:0]);
      FUNC_BRIGHT: begin
        level = (value > 16'(LevelMax)) ? LevelMax : value[3:0];
        queue_command(bright_base_q | {4'b0, level});
      end
      FUNC_NIBBLE: begin
        queue_close();
        queue_bits({2'b0, wr_id_q, addr, value[3:0]}, 14, 1'b1);
      end
      FUNC_BEGIN: begin
        queue_close();
        queue_bits({6'b0, wr_id_q, addr}, 10, 1'b0);
        frame_open_q = 1'b1;
      end
      FUNC_WORD: queue_bits(value, 16, 1'b0);
      FUNC_END:  queue_close();
      default: ;
    endcase
    if (pending_slots.size() > n_before) begin
      tail = pending_slots.pop_back();
      tail.last = 1'b1;
      pending_slots.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One request beat, with an optional idle gap in front
  task automatic send_request(input logic [FuncW-1:0] func,
                              input logic [ValueW-1:0] value,
                              input logic [AddrW-1:0] addr);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_func_i    <= func;
    in_value_i   <= value;
    in_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    serialize_request(func, value, addr);
    if (func <= FUNC_END) sent_requests++;
  endtask

  // Let all outstanding slots drain, then give the block time to settle
  task automatic wait_quiet;
    in_valid_i <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [ByteW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_COMMAND_ID:      cmd_id_q      = data[IdW-1:0];
      CFG_WRITE_ID:        wr_id_q       = data[IdW-1:0];
      CFG_BRIGHTNESS_BASE: bright_base_q = data;
      default: ;
    endcase
  endtask

  task automatic apply_reset;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_func_i    <= '0;
    in_value_i   <= '0;
    in_address_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    cmd_id_q      = 3'd4;
    wr_id_q       = 3'd5;
    bright_base_q = 8'd160;
    frame_open_q  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every request kind and frame corner cases, reset settings
  task automatic test_directed_defaults;
    send_request(FUNC_CMD,    16'h0000, 7'd0);
    send_request(FUNC_CMD,    16'hFFFF, 7'd127);
    send_request(FUNC_BRIGHT, 16'd0,    7'd0);
    send_request(FUNC_BRIGHT, 16'd15,   7'd0);
    send_request(FUNC_BRIGHT, 16'd16,   7'd0);    // clamped
    send_request(FUNC_BRIGHT, 16'hFFFF, 7'd127);  // clamped
    send_request(FUNC_NIBBLE, 16'h0000, 7'd0);
    send_request(FUNC_NIBBLE, 16'hFFFF, 7'd127);
    send_request(FUNC_END,    16'h0000, 7'd0);    // no frame open
    send_request(FUNC_WORD,   16'hFFFF, 7'd0);    // word with no frame
    send_request(FUNC_WORD,   16'h0000, 7'd0);
    send_request(FUNC_BEGIN,  16'h0000, 7'd127);
    send_request(FUNC_WORD,   16'hA5A5, 7'd0);
    send_request(FUNC_WORD,   16'h5A5A, 7'd0);
    send_request(FUNC_BEGIN,  16'hFFFF, 7'd0);    // begin inside a frame
    send_request(FUNC_CMD,    16'h0055, 7'd0);    // command closes the frame
    send_request(FUNC_BEGIN,  16'h0000, 7'h2A);
    send_request(FUNC_NIBBLE, 16'h000A, 7'h55);   // RAM write closes the frame
    send_request(FUNC_BEGIN,  16'h0000, 7'h55);
    send_request(FUNC_BRIGHT, 16'd9,    7'd0);    // brightness closes the frame
    send_request(FUNC_BEGIN,  16'h0000, 7'h7F);
    send_request(FUNC_END,    16'h0000, 7'd0);
    send_request(FUNC_END,    16'h0000, 7'd0);    // nothing left to close
    send_request(FuncRsvd6,   16'hFFFF, 7'd127);
    send_request(FuncRsvd7,   16'hFFFF, 7'd127);
    wait_quiet();
  endtask

  // A few requests that show every register's effect
  task automatic run_register_probe;
    send_request(FUNC_CMD,    16'($urandom_range(0, 65535)), 7'd0);
    send_request(FUNC_BRIGHT, 16'd6,   7'd0);
    send_request(FUNC_BRIGHT, 16'd300, 7'd0);
    send_request(FUNC_NIBBLE, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
    send_request(FUNC_BEGIN,  16'h0000, 7'($urandom_range(0, 127)));
    send_request(FUNC_WORD,   16'($urandom_range(0, 65535)), 7'd0);
    send_request(FUNC_END,    16'h0000, 7'd0);
    wait_quiet();
  endtask

  // Register extremes, masking of wide data, and the unused index
  task automatic test_register_extremes;
    write_register(CFG_COMMAND_ID,      8'h00);
    write_register(CFG_WRITE_ID,        8'h00);
    write_register(CFG_BRIGHTNESS_BASE, 8'h00);
    run_register_probe();
    write_register(CFG_COMMAND_ID,      8'h07);
    write_register(CFG_WRITE_ID,        8'h07);
    write_register(CFG_BRIGHTNESS_BASE, 8'hFF);
    run_register_probe();
    write_register(CFG_COMMAND_ID,      8'hF8);  // upper bits dropped
    write_register(CFG_WRITE_ID,        8'hFA);
    write_register(CFG_BRIGHTNESS_BASE, 8'h5A);
    write_register(CfgRsvdIdx,          8'hFF);  // no register there
    run_register_probe();
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic test_random_traffic(input int target);
    int pick;
    int n_words;
    target += sent_requests;
    while (sent_requests < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        send_request(FUNC_BEGIN, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
        n_words = $urandom_range(1, 6);
        for (int w = 0; w < n_words; w++) begin
          send_request(FUNC_WORD, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
        end
        // Usually closed by frame end, sometimes left open or broken off
        case ($urandom_range(0, 5))
          0: ;
          1: send_request(FUNC_CMD, 16'($urandom_range(0, 65535)), 7'd0);
          default: send_request(FUNC_END, 16'($urandom_range(0, 65535)),
                                7'($urandom_range(0, 127)));
        endcase
      end else if (pick < 13) begin
        send_request(FUNC_CMD, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
      end else if (pick < 15) begin
        send_request(FUNC_BRIGHT,
                     $urandom_range(0, 1) ? 16'($urandom_range(0, 31))
                                          : 16'($urandom_range(0, 65535)),
                     7'($urandom_range(0, 127)));
      end else if (pick < 17) begin
        send_request(FUNC_NIBBLE, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
      end else if (pick < 19) begin
        // Noise: undefined codes, stray ends and stray words
        case ($urandom_range(0, 3))
          0: send_request(FuncRsvd6, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
          1: send_request(FuncRsvd7, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
          2: send_request(FUNC_END,  16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
          default: send_request(FUNC_WORD, 16'($urandom_range(0, 65535)), 7'd0);
        endcase
      end else begin
        // New settings between phases
        wait_quiet();
        write_register(cfg_idx_e'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
      end
    end
    wait_quiet();
  endtask

  initial begin
    err_count     = 0;
    sent_requests = 0;
    cycle_count   = 0;
    stall_left    = 0;
    idle_on       = 1'b1;
    out_stall_i  <= 1'b0;
    apply_reset();
    test_directed_defaults();
    test_register_extremes();
    test_random_traffic(160);
    idle_on = 1'b0;
    test_random_traffic(40);
    if (err_count == 0 && pending_slots.size() == 0) begin
      $display("tb_led_driver_serial_writer_core: PASS");
    end else begin
      $display("tb_led_driver_serial_writer_core: FAIL");
    end
    $finish;
  end

endmodule
